// File: sv/cbc_pkg.sv
// Package for the cell balance controller.
// Holds the field widths, register codes, sequencer states and the structs
// that pass between the top level, the minimum finder and the cell lanes.
package cbc_pkg;

  localparam int IN_CELLS = 6;
  localparam int CELL_W   = 16;
  localparam int NOW_W    = 32;
  localparam int DUTY_W   = 7;
  localparam int CMP_W    = 17;
  localparam int TGT_W    = CELL_W + 1;
  localparam int EXC_W    = CELL_W + 2;
  localparam int CP_W     = DUTY_W + CMP_W;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  localparam logic [DUTY_W-1:0] DUTY_DEFAULT = 7'd60;
  localparam logic [DUTY_W-1:0] DUTY_CEIL    = 7'd100;

  // ceil(2^30 / 100); exact quotient for every dividend below 2^23.
  localparam logic [CP_W-1:0] RECIP_100 = 24'd10737419;
  localparam int              RECIP_SH  = 30;

  typedef enum logic [IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_EN_TH   = 3'd1,
    REG_DIS_TH  = 3'd2,
    REG_MIN_ON  = 3'd3,
    REG_DUTYMAX = 3'd4,
    REG_DEADBND = 3'd5,
    REG_ACTIVE  = 3'd6,
    REG_RELOAD  = 3'd7
  } cbc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_EXC,
    ST_MUL,
    ST_UPD,
    ST_CP,
    ST_CMP,
    ST_OUT
  } cbc_state_e;

  typedef struct packed {
    logic [CFG_W-1:0]  kp_q8;
    logic [CFG_W-1:0]  enable_thresh_mv;
    logic [CFG_W-1:0]  disable_thresh_mv;
    logic [CFG_W-1:0]  min_on_time;
    logic [DUTY_W-1:0] duty_cap;
    logic [CFG_W-1:0]  timer_reload;
  } cbc_cfg_t;

  typedef struct packed {
    logic clr;
    logic ld_exc;
    logic ld_mul;
    logic upd;
    logic ld_cp;
    logic ld_cmp;
  } cbc_lane_ctrl_t;

endpackage

// File: sv/cbc_min.sv
// Lowest-voltage finder over the active cells, plus the deadband offset.
// Depends on cbc_pkg.
module cbc_min import cbc_pkg::*; #(
  parameter int LANES = 6
) (
  input  logic                         clk_i,
  input  logic                         ld_i,
  input  logic [LANES-1:0][CELL_W-1:0] cells_i,
  input  logic [LANES-1:0]             act_i,
  input  logic [CFG_W-1:0]             deadband_i,
  output logic [TGT_W-1:0]             target_o
);

  logic [CELL_W-1:0] low;
  logic [TGT_W-1:0]  target_d, target_q;

  // Cell 0 seeds the search without a check of its act_i bit, so it counts even when inactive.
  always_comb begin
    low = cells_i[0];
    for (int i = 1; i < LANES; i++) begin
      if (act_i[i] && (cells_i[i] < low)) begin
        low = cells_i[i];
      end
    end
    target_d = {1'b0, low} + {1'b0, deadband_i};
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      target_q <= target_d;
    end
  end

  assign target_o = target_q;

endmodule

// File: sv/cbc_lane.sv
// One balancing lane: hysteresis state, duty and PWM compare for one cell.
// Depends on cbc_pkg; sequenced by cbc_lane_ctrl_t from the top level.
module cbc_lane import cbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cbc_lane_ctrl_t      ctrl_i,
  input  cbc_cfg_t            cfg_i,
  input  logic                act_i,
  input  logic [CELL_W-1:0]   cell_mv_i,
  input  logic [TGT_W-1:0]    target_i,
  input  logic [NOW_W-1:0]    now_i,
  output logic [DUTY_W-1:0]   duty_o,
  output logic [CMP_W-1:0]    cmp_o
);

  logic                     bleed_q, bleed_d;
  logic [NOW_W-1:0]         on_since_q, on_since_d;
  logic [DUTY_W-1:0]        last_q, last_d;

  logic signed [EXC_W-1:0]  excess_q;
  logic [NOW_W-1:0]         elapsed_q;
  logic [2*CFG_W-1:0]       prod_q;
  logic                     pos_q, en_hit_q, off_hit_q;
  logic [CP_W-1:0]          cp_q;
  logic [CMP_W-1:0]         cmp_q;

  logic [DUTY_W-1:0]        duty;
  logic [2*CP_W-1:0]        quot_full;

  // Excess is signed: a cell below the target gives a negative value.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_exc) begin
      excess_q  <= $signed({2'b00, cell_mv_i}) - $signed({1'b0, target_i});
      elapsed_q <= now_i - on_since_q;
    end
    if (ctrl_i.ld_mul) begin
      pos_q     <= (excess_q > 0);
      en_hit_q  <= (excess_q >= $signed({2'b00, cfg_i.enable_thresh_mv}));
      off_hit_q <= (excess_q <= $signed({2'b00, cfg_i.disable_thresh_mv})) &&
                   (elapsed_q >= {{(NOW_W-CFG_W){1'b0}}, cfg_i.min_on_time});
      prod_q    <= cfg_i.kp_q8 * excess_q[CELL_W-1:0];
    end
    if (ctrl_i.ld_cp) begin
      cp_q <= {{(CP_W-DUTY_W){1'b0}}, last_q} *
              ({{(CP_W-CFG_W){1'b0}}, cfg_i.timer_reload} + CP_W'(1));
    end
    if (ctrl_i.ld_cmp) begin
      cmp_q <= quot_full[RECIP_SH +: CMP_W];
    end
  end

  assign quot_full = cp_q * RECIP_100;

  always_comb begin
    if (!pos_q) begin
      duty = '0;
    end else if (cfg_i.kp_q8 == '0) begin
      duty = cfg_i.duty_cap;
    end else if (prod_q[2*CFG_W-1:8] > {{(2*CFG_W-8-DUTY_W){1'b0}}, cfg_i.duty_cap}) begin
      duty = cfg_i.duty_cap;
    end else if (prod_q[8 +: DUTY_W] == '0) begin
      duty = DUTY_W'(1);
    end else begin
      duty = prod_q[8 +: DUTY_W];
    end
  end

  always_comb begin
    bleed_d    = bleed_q;
    on_since_d = on_since_q;
    last_d     = last_q;
    if (ctrl_i.clr) begin
      bleed_d    = 1'b0;
      on_since_d = '0;
      last_d     = '0;
    end else if (ctrl_i.upd && act_i) begin
      if (bleed_q && off_hit_q) begin
        bleed_d = 1'b0;
        last_d  = '0;
      end else if (bleed_q || en_hit_q) begin
        if (!bleed_q) begin
          on_since_d = now_i;
        end
        bleed_d = (duty != '0);
        last_d  = duty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bleed_q    <= 1'b0;
      on_since_q <= '0;
      last_q     <= '0;
    end else begin
      bleed_q    <= bleed_d;
      on_since_q <= on_since_d;
      last_q     <= last_d;
    end
  end

  assign duty_o = last_q;
  assign cmp_o  = cmp_q;

endmodule

// File: sv/cell_balance_controller.sv
// Top level of the cell balance controller: registers, sequencer, lanes
// and the output register. Depends on cbc_pkg, cbc_min and cbc_lane.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    six cell mV, now_ms
//   m_axis    out        m_axis_tvalid/m_axis_tready    six duties, six compares
//   cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// A word is accepted only in the idle state and then runs through a fixed
// sequence of minimum search, excess, multiply, state update, compare product
// and reciprocal division, all cells in parallel lanes.
// The result waits in the output register; the next word is taken while it
// waits, and only the final load stalls if the previous result is unread.
// Reset is asynchronous and needs no clearing pass; a configuration write
// clears all per-cell state in the same cycle.
module cell_balance_controller import cbc_pkg::*; #(
  parameter int CELL_CNT = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cell0_mv, cell1_mv, ..., cell5_mv, now_ms
  input  logic [127:0]          s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // duty0 .. duty5, cmp0 .. cmp5
  output logic [143:0]          m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int LANES = (CELL_CNT < IN_CELLS) ? CELL_CNT : IN_CELLS;

  cbc_state_e state_q, state_d;

  cbc_cfg_t         cfg_q, cfg_d;
  logic [CFG_W-1:0] deadband_q, deadband_d;
  logic [IDX_W-1:0] active_q, active_d;
  logic [DUTY_W-1:0] dmax_raw;

  logic [IN_CELLS-1:0][CELL_W-1:0] cells_q;
  logic [NOW_W-1:0]                now_q;
  logic [IDX_W-1:0]                n_act;
  logic [LANES-1:0]                act;
  logic [TGT_W-1:0]                target;

  cbc_lane_ctrl_t ctrl;
  logic           in_acc, out_load, out_valid_q;

  logic [IN_CELLS-1:0][DUTY_W-1:0] lane_duty, duty_q;
  logic [IN_CELLS-1:0][CMP_W-1:0]  lane_cmp, cmp_q;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_d      = cfg_q;
    deadband_d = deadband_q;
    active_d   = active_q;
    dmax_raw   = cfg_data_i[DUTY_W-1:0];
    unique case (cbc_reg_e'(cfg_idx_i))
      REG_KP:      cfg_d.kp_q8             = cfg_data_i;
      REG_EN_TH:   cfg_d.enable_thresh_mv  = cfg_data_i;
      REG_DIS_TH:  cfg_d.disable_thresh_mv = cfg_data_i;
      REG_MIN_ON:  cfg_d.min_on_time       = cfg_data_i;
      REG_DUTYMAX: begin
        if (dmax_raw == '0) begin
          cfg_d.duty_cap = DUTY_DEFAULT;
        end else if (dmax_raw > DUTY_CEIL) begin
          cfg_d.duty_cap = DUTY_CEIL;
        end else begin
          cfg_d.duty_cap = dmax_raw;
        end
      end
      REG_DEADBND: deadband_d          = cfg_data_i;
      REG_ACTIVE:  active_d            = cfg_data_i[IDX_W-1:0];
      REG_RELOAD:  cfg_d.timer_reload  = cfg_data_i;
      default:     cfg_d               = cfg_q;
    endcase
    // The enable threshold never sits below the disable threshold.
    if (cfg_d.enable_thresh_mv < cfg_d.disable_thresh_mv) begin
      cfg_d.enable_thresh_mv = cfg_d.disable_thresh_mv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_q8             <= 16'd230;
      cfg_q.enable_thresh_mv  <= 16'd30;
      cfg_q.disable_thresh_mv <= 16'd10;
      cfg_q.min_on_time       <= 16'd250;
      cfg_q.duty_cap          <= DUTY_DEFAULT;
      cfg_q.timer_reload      <= 16'd999;
      deadband_q              <= '0;
      active_q                <= 3'd6;
    end else if (cfg_we_i) begin
      cfg_q      <= cfg_d;
      deadband_q <= deadband_d;
      active_q   <= active_d;
    end
  end

  assign n_act = (active_q > IDX_W'(LANES)) ? IDX_W'(LANES) : active_q;

  // ------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    ctrl        = '0;
    ctrl.clr    = cfg_we_i;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MIN;
      ST_MIN:  state_d = ST_EXC;
      ST_EXC: begin
        ctrl.ld_exc = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        ctrl.ld_mul = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd = 1'b1;
        state_d  = ST_CP;
      end
      ST_CP: begin
        ctrl.ld_cp = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        ctrl.ld_cmp = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < IN_CELLS; i++) begin
        cells_q[i] <= s_axis_tdata[i*CELL_W +: CELL_W];
      end
      now_q <= s_axis_tdata[IN_CELLS*CELL_W +: NOW_W];
    end
  end

  // ----------------------------------------------------------------- lanes
  cbc_min #(
    .LANES (LANES)
  ) u_min (
    .clk_i      (clk_i),
    .ld_i       (state_q == ST_MIN),
    .cells_i    (cells_q[LANES-1:0]),
    .act_i      (act),
    .deadband_i (deadband_q),
    .target_o   (target)
  );

  for (genvar g = 0; g < IN_CELLS; g++) begin : g_lane
    if (g < LANES) begin : g_used
      assign act[g] = (IDX_W'(g) < n_act);
      cbc_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .cfg_i     (cfg_q),
        .act_i     (act[g]),
        .cell_mv_i (cells_q[g]),
        .target_i  (target),
        .now_i     (now_q),
        .duty_o    (lane_duty[g]),
        .cmp_o     (lane_cmp[g])
      );
    end else begin : g_absent
      assign lane_duty[g] = '0;
      assign lane_cmp[g]  = '0;
    end
  end

  // ---------------------------------------------------------- output merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      duty_q <= lane_duty;
      cmp_q  <= lane_cmp;
    end
  end

  always_comb begin
    for (int i = 0; i < IN_CELLS; i++) begin
      m_axis_tdata[i*DUTY_W +: DUTY_W]                 = duty_q[i];
      m_axis_tdata[IN_CELLS*DUTY_W + i*CMP_W +: CMP_W] = cmp_q[i];
    end
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MIN))
    else $error("accepted word did not start a pass");

  a_thresh_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.enable_thresh_mv >= cfg_q.disable_thresh_mv)
    else $error("enable threshold below disable threshold");

  a_dmax_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.duty_cap != '0) && (cfg_q.duty_cap <= DUTY_CEIL))
    else $error("duty clamp out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(duty_q) && $stable(cmp_q))
    else $error("pending result overwritten");

  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (lane_duty[0] <= DUTY_CEIL))
    else $error("duty above full scale");
`endif

endmodule
